### rtl/kpiw_pkg.sv
// Shared types, codes and constants for the key-protected watchdog.
package kpiw_pkg;

  localparam int unsigned CounterWidthDefault = 12;

  // bus/tick command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // register map
  localparam logic [2:0] REG_KEY      = 3'd0;
  localparam logic [2:0] REG_PRESCALE = 3'd1;
  localparam logic [2:0] REG_RELOAD   = 3'd2;
  localparam logic [2:0] REG_STATUS   = 3'd3;
  localparam logic [2:0] REG_RST_STAT = 3'd4;

  // key values
  localparam logic [15:0] KEY_START   = 16'hCCCC;
  localparam logic [15:0] KEY_REFRESH = 16'hAAAA;
  localparam logic [15:0] KEY_UNLOCK  = 16'h5555;

  localparam int unsigned FLAG_BIT  = 29;
  localparam int unsigned CLEAR_BIT = 24;

  // prescaler select that already gives the largest divider
  localparam logic [2:0] PSC_MAX_SEL = 3'd6;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  reg_select;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        watchdog_reset;
    logic        is_running;
  } out_item_t;

  typedef struct packed {
    logic running;
    logic sticky_flag;
  } core_status_t;

endpackage

### rtl/key_protected_independent_watchdog_unit.sv
// Top level of the key-protected watchdog: input register, core, result register.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one beat per bus
//   write, bus read or tick of the slow watchdog clock. Result channel
//   (out_valid / out_stall / out_data) returns exactly one beat per input
//   beat, in order: read data (zero unless a read), the expiry pulse and the
//   running flag as it stands after the beat.
//   A beat is taken when valid is high and stall is low.
// Flow: an accepted beat lands in the input register; once the result
//   register has room it is executed and its result is registered there,
//   which raises out_valid.
// Throughput: one beat per cycle while out_stall does not hold a full result register.
// Stall: when out_stall holds a full result register, the input register
//   keeps its beat and in_stall rises while that register is occupied;
//   no beat is lost or repeated.
// Reset (rst_n low, synchronous): both registers empty, watchdog stopped,
//   locked, prescaler select 0, reload and counter all ones, flag clear.
// Expiry: the result beat shows watchdog_reset=1 and is_running=0; the
//   sticky flag reads at bit 29 of the reset status register.
module key_protected_independent_watchdog_unit #(
  parameter int unsigned COUNTER_WIDTH = kpiw_pkg::CounterWidthDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  kpiw_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output kpiw_pkg::out_item_t  out_data
);
  import kpiw_pkg::*;

  logic         s1_valid_r, s1_valid_nxt;
  in_item_t     s1_item_r;
  logic         out_valid_r, out_valid_nxt;
  out_item_t    out_item_r;
  logic         advance;
  logic         in_take;
  out_item_t    core_result;
  core_status_t core_status;

  // execute the held beat when the result register has room
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  kpiw_core #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (advance),
    .item   (s1_item_r),
    .result (core_result),
    .status (core_status)
  );

  always_comb begin
    s1_valid_nxt  = in_take || (s1_valid_r && !advance);
    out_valid_nxt = advance || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) s1_item_r <= in_data;
    if (advance) out_item_r <= core_result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // expiry always stops the watchdog and raises the sticky flag
  a_expiry_state: assert property (@(posedge clk) disable iff (!rst_n)
    advance && core_result.watchdog_reset |=> core_status.sticky_flag && !core_status.running)
    else $error("expiry did not stop watchdog / set flag");

  // reported running flag matches the state the core left behind
  a_running_match: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_item_r.is_running == core_status.running)
    else $error("is_running disagrees with core state");

  // a blocked beat in the input register is neither dropped nor altered
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_item_r))
    else $error("held input beat lost or changed");

  // expiry result never reports the watchdog as still running
  a_expiry_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.watchdog_reset |-> !out_item_r.is_running)
    else $error("expiry beat shows running");

endmodule

### rtl/kpiw_core.sv
// Watchdog register file, prescaler and down counter; one beat per commit.
module kpiw_core #(
  parameter int unsigned COUNTER_WIDTH = kpiw_pkg::CounterWidthDefault
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    commit,
  input  kpiw_pkg::in_item_t      item,
  output kpiw_pkg::out_item_t     result,
  output kpiw_pkg::core_status_t  status
);
  import kpiw_pkg::*;

  logic                     running_r, running_nxt;
  logic                     unlocked_r, unlocked_nxt;
  logic [2:0]               psel_r, psel_nxt;
  logic [COUNTER_WIDTH-1:0] reload_r, reload_nxt;
  logic [COUNTER_WIDTH-1:0] ctr_r, ctr_nxt;
  logic [7:0]               pcnt_r, pcnt_nxt;
  logic [1:0]               busy_r, busy_nxt;
  logic                     flag_r, flag_nxt;

  logic [2:0] psel_sat;
  logic [8:0] divider;
  logic [8:0] pcnt_inc;

  assign psel_sat = (psel_r > PSC_MAX_SEL) ? PSC_MAX_SEL : psel_r;
  assign divider  = 9'd4 << psel_sat;
  assign pcnt_inc = {1'b0, pcnt_r} + 9'd1;

  always_comb begin
    running_nxt  = running_r;
    unlocked_nxt = unlocked_r;
    psel_nxt     = psel_r;
    reload_nxt   = reload_r;
    ctr_nxt      = ctr_r;
    pcnt_nxt     = pcnt_r;
    busy_nxt     = busy_r;
    flag_nxt     = flag_r;
    result       = '0;

    unique case (item.command)
      CMD_WRITE: begin
        unique case (item.reg_select)
          REG_KEY: begin
            if (item.write_data[15:0] == KEY_UNLOCK) begin
              unlocked_nxt = 1'b1;
            end else begin
              unlocked_nxt = 1'b0;
              if (item.write_data[15:0] == KEY_START) begin
                running_nxt = 1'b1;
              end else if (item.write_data[15:0] == KEY_REFRESH) begin
                ctr_nxt = reload_r;
              end
            end
          end
          REG_PRESCALE: begin
            if (unlocked_r) begin
              psel_nxt    = item.write_data[2:0];
              busy_nxt[0] = 1'b1;
            end
          end
          REG_RELOAD: begin
            if (unlocked_r) begin
              reload_nxt  = item.write_data[COUNTER_WIDTH-1:0];
              busy_nxt[1] = 1'b1;
            end
          end
          REG_RST_STAT: begin
            if (item.write_data[CLEAR_BIT]) flag_nxt = 1'b0;
          end
          default: ;
        endcase
      end
      CMD_READ: begin
        unique case (item.reg_select)
          REG_PRESCALE: result.read_data = {29'd0, psel_r};
          REG_RELOAD:   result.read_data = 32'(reload_r);
          REG_STATUS:   result.read_data = {30'd0, busy_r};
          REG_RST_STAT: result.read_data = 32'(flag_r) << FLAG_BIT;
          default:      result.read_data = '0;
        endcase
      end
      CMD_TICK: begin
        busy_nxt = '0;
        if (running_r) begin
          if (pcnt_inc >= divider) begin
            pcnt_nxt = '0;
            if (ctr_r == '0) begin
              // expiry: everything but the sticky flag back to reset values
              running_nxt           = 1'b0;
              unlocked_nxt          = 1'b0;
              psel_nxt              = '0;
              reload_nxt            = '1;
              ctr_nxt               = '1;
              flag_nxt              = 1'b1;
              result.watchdog_reset = 1'b1;
            end else begin
              ctr_nxt = ctr_r - 1'b1;
            end
          end else begin
            pcnt_nxt = pcnt_inc[7:0];
          end
        end
      end
      default: ;
    endcase

    result.is_running = running_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r  <= 1'b0;
      unlocked_r <= 1'b0;
      psel_r     <= '0;
      reload_r   <= '1;
      ctr_r      <= '1;
      pcnt_r     <= '0;
      busy_r     <= '0;
      flag_r     <= 1'b0;
    end else if (commit) begin
      running_r  <= running_nxt;
      unlocked_r <= unlocked_nxt;
      psel_r     <= psel_nxt;
      reload_r   <= reload_nxt;
      ctr_r      <= ctr_nxt;
      pcnt_r     <= pcnt_nxt;
      busy_r     <= busy_nxt;
      flag_r     <= flag_nxt;
    end
  end

  assign status.running     = running_r;
  assign status.sticky_flag = flag_r;

endmodule
